### rtl/bds_pkg.sv
// bds_pkg: shared types and constants for the 3x6 box downsampler
package bds_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_W-1:0] MAX_ROWS     = 13'd4096;

  // position counters
  localparam int POS_W = 12;

  // input pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // output block
  typedef struct packed {
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic [9:0] block_col;
    logic [9:0] block_row;
    logic       partial_block;
    logic       frame_end;
  } blk_t;

endpackage

### rtl/box_downsample_3x6_rgb.sv
// box_downsample_3x6_rgb: block-average decimation of an rgb raster stream
// Takes one pixel per cycle in raster order and emits one averaged result per block of
// BLOCK_W pixels by BLOCK_H rows, edge blocks averaged over the pixels present and flagged.
// Throughput is one pixel per clock: each pixel does one read-modify-write of its block
// column's running sums in a single RAM (read registered, written back from the stage
// after the read, with a forwarding register for back-to-back pixels of the same block).
// A block's result passes through the divide stage and the output register; the mean
// comes from a reciprocal table and one multiplier per channel. The input stalls only
// while a result is held at the output. No clearing pass is needed after reset or a
// configuration write: the first pixel of every block starts its sums from zero.
module box_downsample_3x6_rgb #(
  parameter int MAX_GROUPS = 1024,
  parameter int BLOCK_W    = 3,
  parameter int BLOCK_H    = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  bds_pkg::pix_t                     pix,
  output logic                              blk_valid,
  input  logic                              blk_ready,
  output bds_pkg::blk_t                     blk,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SC_W     = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
  localparam int SR_W     = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;
  localparam int BW_W     = $clog2(BLOCK_W + 1);
  localparam int BH_W     = $clog2(BLOCK_H + 1);
  localparam int MAX_CNT  = BLOCK_W * BLOCK_H;
  localparam int CNT_W    = $clog2(MAX_CNT + 1);
  localparam int SUM_W    = $clog2(MAX_CNT * 255 + 1);
  localparam int ENT_W    = 3 * SUM_W;
  localparam int RECIP_SH = SUM_W + CNT_W;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int TAB_N    = 1 << CNT_W;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int POS_W    = bds_pkg::POS_W;

  // configuration registers
  logic [bds_pkg::WIDTH_W-1:0]  image_width;
  logic [bds_pkg::HEIGHT_W-1:0] image_height;
  logic [bds_pkg::WIDTH_W-1:0]  w_eff;
  logic [bds_pkg::HEIGHT_W-1:0] h_eff;
  logic                         restart;

  // position of the next pixel
  logic [POS_W-1:0] pixel_col;
  logic [POS_W-1:0] pixel_row;
  logic [SC_W-1:0]  sub_col;
  logic [SR_W-1:0]  sub_row;
  logic [POS_W-1:0] grp;
  logic [POS_W-1:0] band;

  // decode of the current position
  logic             pix_acc;
  logic             col_end;
  logic             row_end;
  logic             sub_col_last;
  logic             sub_row_last;
  logic             in_range;
  logic [BW_W-1:0]  bw;
  logic [BH_W-1:0]  bh;

  // read-modify-write stage
  logic                 s1_valid;
  bds_pkg::pix_t        s1_pix;
  logic [ADDR_W-1:0]    s1_addr;
  logic                 s1_write;
  logic                 s1_emit;
  logic                 s1_fresh;
  logic [CNT_W-1:0]     s1_cnt;
  logic                 s1_partial;
  logic                 s1_frame_end;
  logic [9:0]           s1_col;
  logic [9:0]           s1_row;
  logic                 s1_done;

  // block column sums
  logic [ENT_W-1:0] mem [MAX_GROUPS];
  logic [ENT_W-1:0] rdata;
  logic             fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [ENT_W-1:0] fwd_ent;
  logic [ENT_W-1:0] base_ent;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [ENT_W-1:0] new_ent;

  // divide stage
  logic             s2_valid;
  logic [SUM_W-1:0] s2_r;
  logic [SUM_W-1:0] s2_g;
  logic [SUM_W-1:0] s2_b;
  logic [CNT_W-1:0] s2_cnt;
  logic             s2_partial;
  logic             s2_frame_end;
  logic [9:0]       s2_col;
  logic [9:0]       s2_row;
  logic             s2_free;
  logic             out_free;
  logic [RECIP_W-1:0] recip_tab [TAB_N];
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_g;
  logic [PROD_W-1:0]  prod_b;

  // configuration write
  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == bds_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == bds_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bds_pkg::WIDTH_RESET;
      image_height <= bds_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bds_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bds_pkg::WIDTH_W-1:0];
        bds_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[bds_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, height clamped
  always_comb begin
    w_eff = (image_width == '0) ? bds_pkg::WIDTH_W'(1) : image_width;
    if (image_height == '0) begin
      h_eff = bds_pkg::HEIGHT_W'(1);
    end else if (image_height > bds_pkg::MAX_ROWS) begin
      h_eff = bds_pkg::MAX_ROWS;
    end else begin
      h_eff = image_height;
    end
  end

  // position decode
  assign pix_acc      = pix_valid && pix_ready;
  assign col_end      = ({1'b0, pixel_col} + 13'd1) >= {1'b0, w_eff};
  assign row_end      = ({1'b0, pixel_row} + 13'd1) >= h_eff;
  assign sub_col_last = sub_col == SC_W'(BLOCK_W - 1);
  assign sub_row_last = sub_row == SR_W'(BLOCK_H - 1);
  assign in_range     = {1'b0, grp} < 13'(MAX_GROUPS);
  assign bw           = BW_W'(sub_col) + BW_W'(1);
  assign bh           = BH_W'(sub_row) + BH_W'(1);

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_col <= '0;
      pixel_row <= '0;
      sub_col   <= '0;
      sub_row   <= '0;
      grp       <= '0;
      band      <= '0;
    end else if (pix_acc) begin
      if (col_end) begin
        pixel_col <= '0;
        sub_col   <= '0;
        grp       <= '0;
        if (row_end) begin
          pixel_row <= '0;
          sub_row   <= '0;
          band      <= '0;
        end else begin
          pixel_row <= pixel_row + POS_W'(1);
          if (sub_row_last) begin
            sub_row <= '0;
            band    <= band + POS_W'(1);
          end else begin
            sub_row <= sub_row + SR_W'(1);
          end
        end
      end else begin
        pixel_col <= pixel_col + POS_W'(1);
        if (sub_col_last) begin
          sub_col <= '0;
          grp     <= grp + POS_W'(1);
        end else begin
          sub_col <= sub_col + SC_W'(1);
        end
      end
    end
  end

  // handshake across the stages
  assign out_free  = !blk_valid || blk_ready;
  assign s2_free   = !s2_valid || out_free;
  assign s1_done   = !s1_valid || !s1_emit || s2_free;
  assign pix_ready = s1_done;

  // pixel into the read-modify-write stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_done) begin
      s1_valid <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pix       <= pix;
      s1_addr      <= grp[ADDR_W-1:0];
      s1_write     <= in_range;
      s1_emit      <= in_range && (sub_col_last || col_end) && (sub_row_last || row_end);
      s1_fresh     <= (sub_col == '0) && (sub_row == '0);
      s1_cnt       <= CNT_W'(bw) * CNT_W'(bh);
      s1_partial   <= (bw != BW_W'(BLOCK_W)) || (bh != BH_W'(BLOCK_H));
      s1_frame_end <= col_end && row_end;
      s1_col       <= grp[9:0];
      s1_row       <= band[9:0];
    end
  end

  // sums ram: read on accept, write back after the add
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      rdata <= mem[grp[ADDR_W-1:0]];
    end
    if (s1_valid && s1_write && s1_done) begin
      mem[s1_addr] <= new_ent;
    end
  end

  // last written entry, for a read that raced its write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_valid && s1_write && s1_done) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_write && s1_done) begin
      fwd_addr <= s1_addr;
      fwd_ent  <= new_ent;
    end
  end

  // accumulate; first pixel of a block starts from zero
  always_comb begin
    if (s1_fresh) begin
      base_ent = '0;
    end else if (fwd_valid && fwd_addr == s1_addr) begin
      base_ent = fwd_ent;
    end else begin
      base_ent = rdata;
    end
    sum_r   = base_ent[2*SUM_W +: SUM_W] + SUM_W'(s1_pix.red);
    sum_g   = base_ent[SUM_W +: SUM_W] + SUM_W'(s1_pix.green);
    sum_b   = base_ent[0 +: SUM_W] + SUM_W'(s1_pix.blue);
    new_ent = {sum_r, sum_g, sum_b};
  end

  // finished block into the divide stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid && s1_emit) begin
      s2_r         <= sum_r;
      s2_g         <= sum_g;
      s2_b         <= sum_b;
      s2_cnt       <= s1_cnt;
      s2_partial   <= s1_partial;
      s2_frame_end <= s1_frame_end;
      s2_col       <= s1_col;
      s2_row       <= s1_row;
    end
  end

  // reciprocal table: ceil(2^RECIP_SH / n), exact floor for every sum in range
  for (genvar gd = 0; gd < TAB_N; gd++) begin : g_recip
    localparam longint unsigned DIV = (gd == 0) ? 1 : gd;
    localparam longint unsigned RV  = ((64'd1 << RECIP_SH) + DIV - 1) / DIV;
    assign recip_tab[gd] = RV[RECIP_W-1:0];
  end

  // mean by multiply and shift
  assign recip  = recip_tab[s2_cnt];
  assign prod_r = PROD_W'(s2_r) * PROD_W'(recip);
  assign prod_g = PROD_W'(s2_g) * PROD_W'(recip);
  assign prod_b = PROD_W'(s2_b) * PROD_W'(recip);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (out_free) begin
      blk_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      blk.avg_red       <= prod_r[RECIP_SH +: 8];
      blk.avg_green     <= prod_g[RECIP_SH +: 8];
      blk.avg_blue      <= prod_b[RECIP_SH +: 8];
      blk.block_col     <= s2_col;
      blk.block_row     <= s2_row;
      blk.partial_block <= s2_partial;
      blk.frame_end     <= s2_frame_end;
    end
  end

  // checks
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    pixel_col < w_eff)
    else $error("pixel column beyond frame width");

  a_sub_col_range: assert property (@(posedge clk) disable iff (rst)
    sub_col <= SC_W'(BLOCK_W - 1))
    else $error("sub-column counter out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_cnt != '0) && (s2_cnt <= CNT_W'(MAX_CNT)))
    else $error("block pixel count out of range");

  a_mean_fits: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (prod_r[PROD_W-1:RECIP_SH+8] == '0) &&
                 (prod_g[PROD_W-1:RECIP_SH+8] == '0) &&
                 (prod_b[PROD_W-1:RECIP_SH+8] == '0))
    else $error("block mean exceeds eight bits");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_done |=> s1_valid && $stable(s1_addr) && $stable(s1_emit))
    else $error("stalled pixel lost from read-modify-write stage");

endmodule
